### rtl/core/time_table_linear_interpolator_macros.svh
// ----------------------------------------------------------------------------
// time table interpolator assertion macros
// short forms for the clocked checks used in the core, sampled on clk and
// switched off while rst is high
// ----------------------------------------------------------------------------
`ifndef TIME_TABLE_LINEAR_INTERPOLATOR_MACROS_SVH
`define TIME_TABLE_LINEAR_INTERPOLATOR_MACROS_SVH

// same-cycle implication
`define TTLI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TTLI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ttli_pkg.sv
// ----------------------------------------------------------------------------
// ttli_pkg
// field widths, opcodes and fixed-point constants of the time table
// interpolator
// ----------------------------------------------------------------------------
package ttli_pkg;

  localparam int WORD_W      = 32;  // signed q16.16 words
  localparam int OPCODE_W    = 1;
  localparam int FACE_W      = 3;
  localparam int SPECIES_W   = 1;
  localparam int ROW_FIELD_W = 8;
  localparam int COLUMN_W    = 4;
  localparam int INDEX_W     = 3;
  localparam int CFG_W       = 4;
  localparam int NCOL_W      = 4;
  localparam int MAX_OUT     = 8;   // results per query at most

  localparam int FRAC_W      = 17;  // q1.16 fraction, 65536 included
  localparam int DIV_CNT_W   = 5;

  localparam logic [FRAC_W-1:0]    FRAC_ONE  = 17'h10000;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST  = 5'd16;

  localparam logic [OPCODE_W-1:0] OP_LOAD  = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_QUERY = 1'b1;

endpackage

### rtl/core/ttli_ram.sv
// ----------------------------------------------------------------------------
// ttli_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ttli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/time_table_linear_interpolator.sv
// ----------------------------------------------------------------------------
// time_table_linear_interpolator
// per face and species time tables of q16.16 rows, loaded one word at a
// time, and piecewise linear lookup of the configured value columns at a query time
// ----------------------------------------------------------------------------
//
// channel   dir  handshake            payload
// -------   ---  -------------------  -------------------------------------------
// cfg       in   cfg_valid/cfg_ready  cfg_data (value_columns)
// in        in   in_valid/in_ready    opcode face species row column word query_time
// out       out  out_valid/out_ready  value_index value table_empty last
//
// a load is written in the load state; a query runs setup, then a row
// search (k rows read, at most the row count), a shift-subtract division
// when it lands between two rows, then per value column two reads, a
// difference, a multiply, a sum and an emit step holding the result
// the row search and the per-column value reads share the one ram read port
// reset clears the row counts at once; table words need no clearing pass
// in_ready is low from the transfer of an item until its last result goes out
// a stalled output holds its register and the sequencer waits on it
//
`include "time_table_linear_interpolator_macros.svh"

module time_table_linear_interpolator #(
  parameter int ROWS    = 256,
  parameter int COLS    = 8,
  parameter int FACES   = 6,
  parameter int SPECIES = 2
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ttli_pkg::CFG_W-1:0]            cfg_data,
  // items
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [ttli_pkg::OPCODE_W-1:0]         opcode,
  input  logic [ttli_pkg::FACE_W-1:0]           face,
  input  logic [ttli_pkg::SPECIES_W-1:0]        species,
  input  logic [ttli_pkg::ROW_FIELD_W-1:0]      row,
  input  logic [ttli_pkg::COLUMN_W-1:0]         column,
  input  logic signed [ttli_pkg::WORD_W-1:0]    word,
  input  logic signed [ttli_pkg::WORD_W-1:0]    query_time,
  // results
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ttli_pkg::INDEX_W-1:0]          value_index,
  output logic signed [ttli_pkg::WORD_W-1:0]    value,
  output logic                                  table_empty,
  output logic                                  last
);

  import ttli_pkg::*;

  localparam int TABLES    = FACES * SPECIES;
  localparam int TAB_W     = (TABLES > 1) ? $clog2(TABLES) : 1;
  localparam int ROW_WORDS = COLS + 1;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int CNT_W     = $clog2(ROWS + 1);
  localparam int COL_W     = $clog2(COLS + 1);
  localparam int DEPTH     = TABLES * ROWS * ROW_WORDS;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NLIM      = (COLS < MAX_OUT) ? COLS : MAX_OUT;

  localparam logic [ADDR_W-1:0] TAB_STEP = ADDR_W'(ROWS * ROW_WORDS);
  localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(ROW_WORDS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SETUP,
    ST_SRCH0,
    ST_SRCH,
    ST_DIV,
    ST_RD1,
    ST_RD2,
    ST_DIFF,
    ST_MUL,
    ST_SUM,
    ST_EMIT
  } state_t;

  state_t state;

  // configuration register
  logic [CFG_W-1:0] value_columns;

  // captured item
  logic [TAB_W-1:0]         tab;
  logic                     qbad;
  logic [ROW_W-1:0]         lrow;
  logic [COL_W-1:0]         lcol;
  logic [WORD_W-1:0]        lword;
  logic signed [WORD_W-1:0] qtime;

  // per table row counts
  logic [CNT_W-1:0] row_count [TABLES];

  // query context
  logic [ADDR_W-1:0] tab_base;
  logic [CNT_W-1:0]  cnt;
  logic [NCOL_W-1:0] ncols;
  logic              is_empty;
  logic [ROW_W-1:0]  srow;
  logic [WORD_W-1:0] prev;
  logic [ROW_W-1:0]  i1;
  logic [ROW_W-1:0]  i2;

  // divider
  logic [WORD_W+1:0]    rem;
  logic [WORD_W+1:0]    den;
  logic [FRAC_W-1:0]    frac;
  logic [DIV_CNT_W-1:0] dcnt;

  // blend datapath
  logic [INDEX_W-1:0]         k;
  logic [WORD_W-1:0]          v1;
  logic signed [WORD_W:0]     diff;
  logic signed [FRAC_W+WORD_W:0] prod;

  // ram port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  // combinational helpers
  logic              in_xfer;
  logic              load_ok;
  logic              query_ok;
  logic [NCOL_W-1:0] ncols_next;
  logic [CNT_W-1:0]  cnt_sel;
  logic              hit;
  logic              srow_last;
  logic [WORD_W:0]   num_w;
  logic [WORD_W:0]   den_w;
  logic [WORD_W+1:0] cand;
  logic              ge;
  logic [WORD_W+1:0] rem_next;
  logic              bit_next;
  logic [INDEX_W-1:0] k_inc;
  logic              last_inc;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;

  // table validity and column clamp
  assign query_ok = (int'(face) < FACES) && (int'(species) < SPECIES);
  assign load_ok  = query_ok && (int'(row) < ROWS) && (int'(column) <= COLS);

  always_comb begin
    if (value_columns == '0) begin
      ncols_next = NCOL_W'(1);
    end else if (int'(value_columns) > NLIM) begin
      ncols_next = NCOL_W'(NLIM);
    end else begin
      ncols_next = NCOL_W'(value_columns);
    end
  end

  assign cnt_sel = row_count[tab];

  // row search: first row whose time is at or after the query time
  assign hit       = $signed(ram_rdata) >= qtime;
  assign srow_last = (CNT_W'(srow) + CNT_W'(1)) == cnt;
  assign num_w     = {qtime[WORD_W-1], qtime} - {prev[WORD_W-1], prev};
  assign den_w     = {ram_rdata[WORD_W-1], ram_rdata} - {prev[WORD_W-1], prev};

  // one shift-subtract step; the first step takes the whole-number bit
  assign cand     = (dcnt == '0) ? rem : {rem[WORD_W:0], 1'b0};
  assign ge       = cand >= den;
  assign rem_next = ge ? (cand - den) : cand;
  assign bit_next = ge;

  assign k_inc    = k + INDEX_W'(1);
  assign last_inc = (NCOL_W'(k_inc) + NCOL_W'(1)) == ncols;

  // ram write on loads
  assign ram_we    = (state == ST_LOAD);
  assign ram_waddr = ADDR_W'(tab) * TAB_STEP + ADDR_W'(lrow) * ROW_STEP + ADDR_W'(lcol);

  // ram read address per step
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state)
      ST_SRCH0: begin
        ram_re    = 1'b1;
        ram_raddr = tab_base;
      end
      ST_SRCH: begin
        // prefetch the next row time while this one is compared
        ram_re    = !srow_last;
        ram_raddr = tab_base + (ADDR_W'(srow) + ADDR_W'(1)) * ROW_STEP;
      end
      ST_RD1: begin
        ram_re    = 1'b1;
        ram_raddr = tab_base + ADDR_W'(i1) * ROW_STEP + ADDR_W'(k) + ADDR_W'(1);
      end
      ST_RD2: begin
        ram_re    = 1'b1;
        ram_raddr = tab_base + ADDR_W'(i2) * ROW_STEP + ADDR_W'(k) + ADDR_W'(1);
      end
      default: begin
        ram_re    = 1'b0;
        ram_raddr = '0;
      end
    endcase
  end

  ttli_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_words (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (lword),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // sequencer, control state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      value_columns <= CFG_W'(1);
      out_valid     <= 1'b0;
      for (int t = 0; t < TABLES; t++) begin
        row_count[t] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        value_columns <= cfg_data;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            tab   <= query_ok ? TAB_W'(int'(species) * FACES + int'(face)) : '0;
            qbad  <= !query_ok;
            lrow  <= ROW_W'(row);
            lcol  <= COL_W'(column);
            lword <= word;
            qtime <= query_time;
            if (opcode == OP_QUERY) begin
              state <= ST_SETUP;
            end else if (load_ok) begin
              state <= ST_LOAD;
            end
            // a load outside the tables is dropped
          end
        end

        ST_LOAD: begin
          // a time write sets the row count, also shrinking the table
          if (lcol == '0) begin
            row_count[tab] <= CNT_W'(lrow) + CNT_W'(1);
          end
          state <= ST_IDLE;
        end

        ST_SETUP: begin
          tab_base <= ADDR_W'(tab) * TAB_STEP;
          cnt      <= cnt_sel;
          ncols    <= ncols_next;
          is_empty <= qbad || (cnt_sel == '0);
          k        <= '0;
          if (qbad || (cnt_sel == '0)) begin
            // empty or invalid table: zero results, flagged
            value_index <= '0;
            value       <= '0;
            table_empty <= 1'b1;
            last        <= (ncols_next == NCOL_W'(1));
            out_valid   <= 1'b1;
            state       <= ST_EMIT;
          end else begin
            state <= ST_SRCH0;
          end
        end

        ST_SRCH0: begin
          srow  <= '0;
          state <= ST_SRCH;
        end

        ST_SRCH: begin
          if (hit) begin
            if (srow == '0) begin
              // at or before the first row: clamp to row 0
              i1    <= '0;
              i2    <= '0;
              frac  <= '0;
              state <= ST_RD1;
            end else begin
              // bracketed: t1 < t <= t2, both differences positive
              i1    <= srow - ROW_W'(1);
              i2    <= srow;
              rem   <= {1'b0, num_w};
              den   <= {1'b0, den_w};
              frac  <= '0;
              dcnt  <= '0;
              state <= ST_DIV;
            end
          end else if (srow_last) begin
            // past the last row: clamp to it
            i1    <= srow;
            i2    <= srow;
            frac  <= '0;
            state <= ST_RD1;
          end else begin
            prev <= ram_rdata;
            srow <= srow + ROW_W'(1);
          end
        end

        ST_DIV: begin
          rem  <= rem_next;
          frac <= {frac[FRAC_W-2:0], bit_next};
          dcnt <= dcnt + DIV_CNT_W'(1);
          if (dcnt == DIV_LAST) begin
            state <= ST_RD1;
          end
        end

        ST_RD1: begin
          state <= ST_RD2;
        end

        ST_RD2: begin
          v1    <= ram_rdata;
          state <= ST_DIFF;
        end

        ST_DIFF: begin
          diff  <= $signed({ram_rdata[WORD_W-1], ram_rdata}) - $signed({v1[WORD_W-1], v1});
          state <= ST_MUL;
        end

        ST_MUL: begin
          prod  <= $signed({1'b0, frac}) * diff;
          state <= ST_SUM;
        end

        ST_SUM: begin
          // v1 + floor(s * (v2 - v1) / 65536), wraps to 32 bits
          value_index <= k;
          value       <= v1 + prod[WORD_W+15:16];
          table_empty <= 1'b0;
          last        <= (NCOL_W'(k) + NCOL_W'(1)) == ncols;
          out_valid   <= 1'b1;
          state       <= ST_EMIT;
        end

        ST_EMIT: begin
          if (out_ready) begin
            if (last) begin
              out_valid <= 1'b0;
              state     <= ST_IDLE;
            end else begin
              k <= k_inc;
              if (is_empty) begin
                value_index <= k_inc;
                last        <= last_inc;
              end else begin
                out_valid <= 1'b0;
                state     <= ST_RD1;
              end
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  `TTLI_ASSERT_IMP(a_busy_while_out, out_valid, !in_ready, "input taken while a result waits")
  `TTLI_ASSERT_IMP(a_frac_range, state == ST_RD1, frac <= FRAC_ONE, "fraction above one")
  `TTLI_ASSERT_IMP(a_empty_zero, out_valid && table_empty, value == '0, "empty table gives nonzero")
  `TTLI_ASSERT_IMP(a_srow_range, state == ST_SRCH, CNT_W'(srow) < cnt, "search past row count")
  `TTLI_ASSERT_NXT(a_run_goes_on, out_valid && out_ready && !last, state != ST_IDLE, "query run cut short")

endmodule
